// ===== hdl/rsc_pkg.sv =====
`default_nettype none
package rsc_pkg;

	localparam int DEF_STACK_DEPTH = 64;
	localparam int DEF_VALUE_WIDTH = 32;

	// multiplier consumes this many multiplier bits per cycle
	localparam int MUL_DIGIT = 8;

	localparam int FUNC_W    = 3;
	localparam int OPV_W     = 32;
	localparam int TOP_W     = 32;
	localparam int SDEPTH_W  = 7;
	localparam int STATUS_W  = 3;
	localparam int S_TDATA_W = 32;
	localparam int S_TUSER_W = 3;
	localparam int M_TDATA_W = 40;
	localparam int M_TUSER_W = 3;

	typedef enum logic [FUNC_W-1:0] {
		FN_PUSH = 3'd0,
		FN_ADD  = 3'd1,
		FN_SUB  = 3'd2,
		FN_MUL  = 3'd3,
		FN_DIV  = 3'd4,
		FN_POW  = 3'd5
	} rsc_func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 3'd0,
		ST_UNDER  = 3'd1,
		ST_OVER   = 3'd2,
		ST_DIVZ   = 3'd3,
		ST_NEGEXP = 3'd4
	} rsc_status_t;

	typedef enum logic [1:0] {
		MS_AB,
		MS_ACC_SQ,
		MS_SQ_SQ
	} rsc_mul_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_MUL_WAIT,
		S_DIV_WAIT,
		S_POW_TEST,
		S_POW_ACC,
		S_POW_SQS,
		S_POW_SQ,
		S_RESULT
	} rsc_state_t;

	typedef struct packed {
		logic         take;
		logic         push;
		logic         commit;
		logic         mul_start;
		rsc_mul_sel_t mul_sel;
		logic         div_start;
		logic         pow_init;
		logic         acc_load;
		logic         sq_load;
		logic         exp_shift;
		logic         out_load;
		rsc_status_t  status;
	} rsc_cmd_t;

	typedef struct packed {
		rsc_func_t func;
		logic      full;
		logic      under;
		logic      b_zero;
		logic      b_neg;
		logic      mul_busy;
		logic      div_busy;
		logic      exp_zero;
		logic      exp_lsb;
		logic      exp_one;
		logic      out_free;
	} rsc_stat_t;

endpackage
`default_nettype wire

// ===== hdl/rsc_ram.sv =====
`default_nettype none
module rsc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== hdl/rsc_mul.sv =====
`default_nettype none
module rsc_mul #(
	parameter int W = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] x,
	input  wire logic [W-1:0] y,
	output logic              busy,
	output logic      [W-1:0] prod
);

	import rsc_pkg::*;

	logic [W-1:0]           mc_q;
	logic [W-1:0]           mp_q;
	logic [W-1:0]           prod_q;
	logic                   busy_q;
	logic [W+MUL_DIGIT-1:0] part;
	logic [W-1:0]           mp_next;

	// low W bits of the product only: results wrap
	assign part    = mc_q * mp_q[MUL_DIGIT-1:0];
	assign mp_next = mp_q >> MUL_DIGIT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && mp_next == '0) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mc_q   <= x;
			mp_q   <= y;
			prod_q <= '0;
		end else if (busy_q) begin
			prod_q <= prod_q + part[W-1:0];
			mc_q   <= mc_q << MUL_DIGIT;
			mp_q   <= mp_next;
		end
	end

	assign busy = busy_q;
	assign prod = prod_q;

endmodule
`default_nettype wire

// ===== hdl/rsc_div.sv =====
`default_nettype none
module rsc_div #(
	parameter int W = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] dvd,
	input  wire logic [W-1:0] dvs,
	output logic              busy,
	output logic      [W-1:0] quo
);

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  quo_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  dvs_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [W-1:0]  dvd_mag;
	logic [W-1:0]  dvs_mag;
	logic [W:0]    trial;
	logic [W:0]    diff;
	logic          ge;

	// magnitude of the most negative value still fits as unsigned
	assign dvd_mag = dvd[W-1] ? ('0 - dvd) : dvd;
	assign dvs_mag = dvs[W-1] ? ('0 - dvs) : dvs;

	assign trial = {rem_q, quo_q[W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dvd_mag;
			rem_q <= '0;
			dvs_q <= dvs_mag;
			neg_q <= dvd[W-1] ^ dvs[W-1];
		end else if (busy_q) begin
			rem_q <= ge ? diff[W-1:0] : trial[W-1:0];
			quo_q <= {quo_q[W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quo  = neg_q ? ('0 - quo_q) : quo_q;

endmodule
`default_nettype wire

// ===== hdl/rsc_datapath.sv =====
`default_nettype none
module rsc_datapath #(
	parameter int STACK_DEPTH = rsc_pkg::DEF_STACK_DEPTH,
	parameter int VALUE_WIDTH = rsc_pkg::DEF_VALUE_WIDTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire rsc_pkg::rsc_cmd_t             cmd,
	output rsc_pkg::rsc_stat_t                 stat,
	input  wire logic [rsc_pkg::S_TDATA_W-1:0] s_tdata,
	input  wire logic [rsc_pkg::S_TUSER_W-1:0] s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic      [rsc_pkg::M_TDATA_W-1:0] m_tdata,
	output logic      [rsc_pkg::M_TUSER_W-1:0] m_tuser
);

	import rsc_pkg::*;

	localparam int W  = VALUE_WIDTH;
	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	rsc_func_t       func_q;
	logic [OPV_W-1:0] opv_q;
	logic [W-1:0]    top_q;
	logic [DW-1:0]   depth_q;
	logic [W-1:0]    acc_q;
	logic [W-1:0]    sq_q;
	logic [W-1:0]    exp_q;
	logic [W-1:0]    a_val;
	logic [W-1:0]    b_val;
	logic [W-1:0]    push_val;
	logic [W-1:0]    res;
	logic [W-1:0]    mul_x;
	logic [W-1:0]    mul_y;
	logic [W-1:0]    prod;
	logic [W-1:0]    quo;
	logic            mul_busy;
	logic            div_busy;
	logic [DW-1:0]   dm1;
	logic [DW-1:0]   dm2;
	logic            ram_we;
	logic            out_valid_q;
	logic [M_TDATA_W-1:0] out_data_q;
	logic [M_TUSER_W-1:0] out_user_q;
	logic [TOP_W-1:0]     top_out;

	// top of stack lives in top_q; the RAM holds the entries below it
	assign dm1    = depth_q - DW'(1);
	assign dm2    = depth_q - DW'(2);
	assign b_val  = top_q;
	assign ram_we = cmd.push && depth_q != '0;

	rsc_ram #(
		.WIDTH (W),
		.DEPTH (STACK_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (dm1[AW-1:0]),
		.wdata (top_q),
		.re    (cmd.take),
		.raddr (dm2[AW-1:0]),
		.rdata (a_val)
	);

	always_comb begin
		case (cmd.mul_sel)
			MS_ACC_SQ: begin
				mul_x = acc_q;
				mul_y = sq_q;
			end
			MS_SQ_SQ: begin
				mul_x = sq_q;
				mul_y = sq_q;
			end
			default: begin
				mul_x = a_val;
				mul_y = b_val;
			end
		endcase
	end

	rsc_mul #(.W(W)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.x      (mul_x),
		.y      (mul_y),
		.busy   (mul_busy),
		.prod   (prod)
	);

	rsc_div #(.W(W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.dvd    (a_val),
		.dvs    (b_val),
		.busy   (div_busy),
		.quo    (quo)
	);

	assign push_val = W'($signed(opv_q));

	always_comb begin
		case (func_q)
			FN_ADD:  res = a_val + b_val;
			FN_SUB:  res = a_val - b_val;
			FN_MUL:  res = prod;
			FN_DIV:  res = quo;
			FN_POW:  res = acc_q;
			default: res = top_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else if (cmd.push) begin
			depth_q <= depth_q + DW'(1);
		end else if (cmd.commit) begin
			depth_q <= dm1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			func_q <= rsc_func_t'(s_tuser[FUNC_W-1:0]);
			opv_q  <= s_tdata[OPV_W-1:0];
		end
		if (cmd.push) begin
			top_q <= push_val;
		end else if (cmd.commit) begin
			top_q <= res;
		end
		if (cmd.pow_init) begin
			acc_q <= W'(1);
			sq_q  <= a_val;
			exp_q <= b_val;
		end else begin
			if (cmd.acc_load) begin
				acc_q <= prod;
			end
			if (cmd.sq_load) begin
				sq_q <= prod;
			end
			if (cmd.exp_shift) begin
				exp_q <= exp_q >> 1;
			end
		end
	end

	// output register frees the core while a result waits
	assign top_out = (depth_q != '0) ? TOP_W'($signed(top_q)) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= M_TDATA_W'({SDEPTH_W'(depth_q), top_out});
			out_user_q <= M_TUSER_W'(cmd.status);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	assign stat.func     = func_q;
	assign stat.full     = depth_q == DW'(STACK_DEPTH);
	assign stat.under    = depth_q < DW'(2);
	assign stat.b_zero   = b_val == '0;
	assign stat.b_neg    = b_val[W-1];
	assign stat.mul_busy = mul_busy;
	assign stat.div_busy = div_busy;
	assign stat.exp_zero = exp_q == '0;
	assign stat.exp_lsb  = exp_q[0];
	assign stat.exp_one  = exp_q[W-1:1] == '0;
	assign stat.out_free = !out_valid_q || m_tready;

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DW'(STACK_DEPTH))
		else $error("stack depth beyond capacity");

	a_commit_two: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> depth_q >= DW'(2))
		else $error("operator committed with fewer than two entries");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |=> depth_q == $past(depth_q) + DW'(1))
		else $error("push did not grow the stack");

endmodule
`default_nettype wire

// ===== hdl/rsc_ctrl.sv =====
`default_nettype none
module rsc_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire rsc_pkg::rsc_stat_t stat,
	output rsc_pkg::rsc_cmd_t       cmd
);

	import rsc_pkg::*;

	rsc_state_t  state_q;
	rsc_state_t  state_d;
	rsc_status_t status_q;
	rsc_status_t status_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			status_q <= ST_OK;
		end else begin
			state_q <= state_d;
			if (state_q == S_CHECK) begin
				status_q <= status_d;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		status_d   = ST_OK;
		cmd        = '0;
		cmd.status = status_q;
		s_tready   = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.take = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				state_d = S_RESULT;
				case (stat.func)
					FN_PUSH: begin
						if (stat.full) begin
							status_d = ST_OVER;
						end else begin
							cmd.push = 1'b1;
						end
					end
					FN_ADD, FN_SUB: begin
						if (stat.under) begin
							status_d = ST_UNDER;
						end else begin
							cmd.commit = 1'b1;
						end
					end
					FN_MUL: begin
						if (stat.under) begin
							status_d = ST_UNDER;
						end else begin
							cmd.mul_start = 1'b1;
							cmd.mul_sel   = MS_AB;
							state_d       = S_MUL_WAIT;
						end
					end
					FN_DIV: begin
						if (stat.under) begin
							status_d = ST_UNDER;
						end else if (stat.b_zero) begin
							status_d = ST_DIVZ;
						end else begin
							cmd.div_start = 1'b1;
							state_d       = S_DIV_WAIT;
						end
					end
					FN_POW: begin
						if (stat.under) begin
							status_d = ST_UNDER;
						end else if (stat.b_neg) begin
							status_d = ST_NEGEXP;
						end else begin
							cmd.pow_init = 1'b1;
							state_d      = S_POW_TEST;
						end
					end
					default: begin
						status_d = ST_OK;
					end
				endcase
			end
			S_MUL_WAIT: begin
				if (!stat.mul_busy) begin
					cmd.commit = 1'b1;
					state_d    = S_RESULT;
				end
			end
			S_DIV_WAIT: begin
				if (!stat.div_busy) begin
					cmd.commit = 1'b1;
					state_d    = S_RESULT;
				end
			end
			// square-and-multiply, exponent LSB first
			S_POW_TEST: begin
				if (stat.exp_zero) begin
					cmd.commit = 1'b1;
					state_d    = S_RESULT;
				end else if (stat.exp_lsb) begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = MS_ACC_SQ;
					state_d       = S_POW_ACC;
				end else begin
					state_d = S_POW_SQS;
				end
			end
			S_POW_ACC: begin
				if (!stat.mul_busy) begin
					cmd.acc_load = 1'b1;
					state_d      = S_POW_SQS;
				end
			end
			S_POW_SQS: begin
				// no exponent bits left above this one: square not needed
				if (stat.exp_one) begin
					cmd.commit = 1'b1;
					state_d    = S_RESULT;
				end else begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = MS_SQ_SQ;
					state_d       = S_POW_SQ;
				end
			end
			S_POW_SQ: begin
				if (!stat.mul_busy) begin
					cmd.sq_load   = 1'b1;
					cmd.exp_shift = 1'b1;
					state_d       = S_POW_TEST;
				end
			end
			S_RESULT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	a_mul_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_start |-> !stat.mul_busy)
		else $error("multiplier started while busy");

	a_take_check: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |=> state_q == S_CHECK)
		else $error("accepted transfer not followed by check");

	a_out_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> stat.out_free)
		else $error("result loaded over a pending one");

endmodule
`default_nettype wire

// ===== hdl/rpn_stack_calculator.sv =====
// channel  dir  tdata                                   tuser
// s_*      in   [31:0] operand_value                    [2:0] func
// m_*      out  [31:0] top_value, [38:32] stack_depth   [2:0] status
//
// One item at a time. Push, add, subtract and ignored codes pass through the check and result states.
// Multiply: 8-bit digit multiplier, early exit.
// Divide: restoring divider, one quotient bit per cycle.
// Power: per exponent bit up to two passes of the shared multiplier.
// arst_n clears the stack depth; a result waiting in the output register
// does not block the next transfer in, only the next result.
`default_nettype none
module rpn_stack_calculator #(
	parameter int STACK_DEPTH = rsc_pkg::DEF_STACK_DEPTH,
	parameter int VALUE_WIDTH = rsc_pkg::DEF_VALUE_WIDTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [rsc_pkg::S_TDATA_W-1:0] s_tdata,  // [31:0] operand_value
	input  wire logic [rsc_pkg::S_TUSER_W-1:0] s_tuser,  // [2:0] func
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic      [rsc_pkg::M_TDATA_W-1:0] m_tdata,  // [31:0] top_value, [38:32] stack_depth
	output logic      [rsc_pkg::M_TUSER_W-1:0] m_tuser   // [2:0] status
);

	import rsc_pkg::*;

	rsc_cmd_t  cmd;
	rsc_stat_t stat;

	rsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rsc_datapath #(
		.STACK_DEPTH (STACK_DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
`default_nettype wire
